[hw/rtl/icc_pkg.sv]
// ----------------------------------------------------------------------------
// icc_pkg: shared types and constants of the incubator climate controller
// Event and phase codes, register indexes, fixed thresholds and the structs
// passed between the configuration, vent and evaluation logic.
// ----------------------------------------------------------------------------
`default_nettype none

package icc_pkg;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_START  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PHASE_OFF     = 2'd0,
        PHASE_PREHEAT = 2'd1,
        PHASE_NORMAL  = 2'd2,
        PHASE_HATCH   = 2'd3
    } phase_t;

    localparam int CFG_INDEX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEAT_ON_BELOW  = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HEAT_OFF_ABOVE = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OVERHEAT_LIMIT = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NORMAL_HUM_MIN = 4'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_NORMAL_HUM_MAX = 4'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HATCH_HUM_MIN  = 4'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HATCH_HUM_MAX  = 4'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_VENT_REST      = 4'd7;

    localparam logic [11:0] RST_HEAT_ON_BELOW  = 12'd592;
    localparam logic [11:0] RST_HEAT_OFF_ABOVE = 12'd616;
    localparam logic [11:0] RST_OVERHEAT_LIMIT = 12'd624;
    localparam logic [9:0]  RST_NORMAL_HUM_MIN = 10'd450;
    localparam logic [9:0]  RST_NORMAL_HUM_MAX = 10'd650;
    localparam logic [9:0]  RST_HATCH_HUM_MIN  = 10'd750;
    localparam logic [9:0]  RST_HATCH_HUM_MAX  = 10'd900;
    localparam logic [15:0] RST_VENT_REST      = 16'd300;

    localparam logic [9:0] HUM_FULL         = 10'd1000;
    localparam logic [7:0] FAN_SLOW         = 8'd70;
    localparam logic [7:0] FAN_FAST         = 8'd255;
    localparam logic [7:0] FAN_OFF          = 8'd0;
    localparam int         VENT_RUN_SECONDS = 10;
    localparam logic [4:0] FIRST_TURN_DAY   = 5'd3;
    localparam logic [4:0] AFTERNOON_HOUR   = 5'd13;

    typedef struct packed {
        logic [11:0] heat_on_below;
        logic [11:0] heat_off_above;
        logic [11:0] overheat_limit;
        logic [9:0]  normal_hum_min;
        logic [9:0]  normal_hum_max;
        logic [9:0]  hatch_hum_min;
        logic [9:0]  hatch_hum_max;
        logic [15:0] vent_rest_seconds;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        phase_t      phase;
        logic [11:0] temperature;
        logic [9:0]  humidity;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } item_t;

    typedef struct packed {
        logic       force_vent;
        logic       running;
        logic [7:0] fan_level;
    } vent_state_t;

    typedef struct packed {
        logic        heater;
        vent_state_t vent;
        logic [5:0]  last_buzz_minute;
        logic [4:0]  last_checked_hour;
        logic [7:0]  turns_done;
        logic        next_turn_forward;
    } ctl_state_t;

    typedef struct packed {
        logic       heater_on;
        logic       vent_on;
        logic [7:0] fan_speed;
        logic       buzz;
        logic       turn_request;
        logic       turn_direction;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/icc_cfg.sv]
// ----------------------------------------------------------------------------
// icc_cfg: configuration register file
// Eight threshold and timing registers written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module icc_cfg
    import icc_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            // indexes past the list are dropped
            unique case (cfg_index)
                REG_HEAT_ON_BELOW:  cfg_next.heat_on_below     = cfg_data[11:0];
                REG_HEAT_OFF_ABOVE: cfg_next.heat_off_above    = cfg_data[11:0];
                REG_OVERHEAT_LIMIT: cfg_next.overheat_limit    = cfg_data[11:0];
                REG_NORMAL_HUM_MIN: cfg_next.normal_hum_min    = cfg_data[9:0];
                REG_NORMAL_HUM_MAX: cfg_next.normal_hum_max    = cfg_data[9:0];
                REG_HATCH_HUM_MIN:  cfg_next.hatch_hum_min     = cfg_data[9:0];
                REG_HATCH_HUM_MAX:  cfg_next.hatch_hum_max     = cfg_data[9:0];
                REG_VENT_REST:      cfg_next.vent_rest_seconds = cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heat_on_below     <= RST_HEAT_ON_BELOW;
            cfg_reg.heat_off_above    <= RST_HEAT_OFF_ABOVE;
            cfg_reg.overheat_limit    <= RST_OVERHEAT_LIMIT;
            cfg_reg.normal_hum_min    <= RST_NORMAL_HUM_MIN;
            cfg_reg.normal_hum_max    <= RST_NORMAL_HUM_MAX;
            cfg_reg.hatch_hum_min     <= RST_HATCH_HUM_MIN;
            cfg_reg.hatch_hum_max     <= RST_HATCH_HUM_MAX;
            cfg_reg.vent_rest_seconds <= RST_VENT_REST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/icc_vent.sv]
// ----------------------------------------------------------------------------
// icc_vent: one second of the vent cycle
// Counts toward the current target and toggles between a 10 s fan run and
// the configured rest; forced venting cuts a run or rest short and runs fast.
// ----------------------------------------------------------------------------
`default_nettype none

module icc_vent
    import icc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                   step,
    input  wire logic                   force_in,
    input  vent_state_t                 vent_in,
    input  wire logic [COUNT_WIDTH-1:0] elapsed_in,
    input  wire logic [COUNT_WIDTH-1:0] target_in,
    input  wire logic [15:0]            rest_seconds,
    output vent_state_t                 vent_out,
    output logic [COUNT_WIDTH-1:0]      elapsed_out,
    output logic [COUNT_WIDTH-1:0]      target_out
);

    localparam int RW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [RW-1:0]          rest_ext;
    logic [RW-1:0]          max_ext;
    logic [COUNT_WIDTH-1:0] rest_sat;

    assign rest_ext = RW'(rest_seconds);
    assign max_ext  = RW'(CNT_MAX);
    assign rest_sat = (rest_ext > max_ext) ? CNT_MAX : COUNT_WIDTH'(rest_ext);

    always_comb begin
        vent_out            = vent_in;
        vent_out.force_vent = force_in;
        elapsed_out         = elapsed_in;
        target_out          = target_in;
        if (step) begin
            if (force_in) begin
                target_out = '0;
            end
            if (elapsed_in != CNT_MAX) begin
                elapsed_out = elapsed_in + 1'b1;
            end
            if (elapsed_out >= target_out) begin
                elapsed_out = '0;
                if (!vent_in.running) begin
                    vent_out.running    = 1'b1;
                    vent_out.fan_level  = force_in ? FAN_FAST : FAN_SLOW;
                    vent_out.force_vent = 1'b0;
                    target_out          = COUNT_WIDTH'(VENT_RUN_SECONDS);
                end else begin
                    vent_out.running   = 1'b0;
                    vent_out.fan_level = FAN_OFF;
                    target_out         = rest_sat;
                end
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/icc_eval.sv]
// ----------------------------------------------------------------------------
// icc_eval: per-event evaluation
// Heater hysteresis, overheat vent step, humidity alarm, turn scheduling and
// the tick and start events; gives the next state and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module icc_eval
    import icc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  item_t                       item,
    input  cfg_t                        cfg,
    input  ctl_state_t                  st_in,
    input  wire logic [COUNT_WIDTH-1:0] elapsed_in,
    input  wire logic [COUNT_WIDTH-1:0] target_in,
    output ctl_state_t                  st_out,
    output logic [COUNT_WIDTH-1:0]      elapsed_out,
    output logic [COUNT_WIDTH-1:0]      target_out,
    output result_t                     result
);

    logic        is_sample;
    logic        phase_on;
    logic        overheat;
    logic        vent_step;
    logic        vent_force;
    vent_state_t vent_new;
    logic [9:0]  hum_lo;
    logic [9:0]  hum_hi;
    logic        hum_high;
    logic        hum_bad;
    logic [5:0]  wanted;
    logic        buzz;
    logic        turn;
    logic        dir;

    assign is_sample = (item.mode == MODE_SAMPLE);
    assign phase_on  = (item.phase != PHASE_OFF);
    assign overheat  = is_sample && phase_on &&
                       ($signed(item.temperature) > $signed(cfg.overheat_limit));
    // the vent only moves in the normal and hatching phases
    assign vent_step = ((item.mode == MODE_TICK) || overheat) &&
                       ((item.phase == PHASE_NORMAL) || (item.phase == PHASE_HATCH));
    assign vent_force = overheat | st_in.vent.force_vent;

    icc_vent #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_vent (
        .step         (vent_step),
        .force_in     (vent_force),
        .vent_in      (st_in.vent),
        .elapsed_in   (elapsed_in),
        .target_in    (target_in),
        .rest_seconds (cfg.vent_rest_seconds),
        .vent_out     (vent_new),
        .elapsed_out  (elapsed_out),
        .target_out   (target_out)
    );

    always_comb begin
        unique case (item.phase)
            PHASE_NORMAL: begin
                hum_lo = cfg.normal_hum_min;
                hum_hi = cfg.normal_hum_max;
            end
            PHASE_HATCH: begin
                hum_lo = cfg.hatch_hum_min;
                hum_hi = cfg.hatch_hum_max;
            end
            default: begin
                hum_lo = '0;
                hum_hi = HUM_FULL;
            end
        endcase
    end

    assign hum_high = item.humidity > hum_hi;
    assign hum_bad  = hum_high || (item.humidity < hum_lo);
    // turns due by this day and hour: two a day, the second after noon
    assign wanted   = {item.day, 1'b0} - 6'd1 - {5'd0, (item.hour < AFTERNOON_HOUR)};

    always_comb begin
        st_out      = st_in;
        st_out.vent = vent_new;
        buzz        = 1'b0;
        turn        = 1'b0;
        dir         = 1'b0;
        unique case (item.mode)
            MODE_SAMPLE: begin
                if (!phase_on) begin
                    st_out.heater = 1'b0;
                end else begin
                    if (overheat) begin
                        st_out.heater = 1'b0;
                    end
                    if ($signed(item.temperature) > $signed(cfg.heat_off_above)) begin
                        st_out.heater = 1'b0;
                    end else if ($signed(item.temperature) < $signed(cfg.heat_on_below)) begin
                        st_out.heater = 1'b1;
                    end
                end
                if (hum_bad) begin
                    if (st_in.last_buzz_minute != item.minute) begin
                        st_out.last_buzz_minute = item.minute;
                        buzz                    = 1'b1;
                    end
                    if (hum_high) begin
                        st_out.vent.force_vent = 1'b1;
                    end
                end
                if ((item.phase == PHASE_NORMAL) &&
                    (st_in.last_checked_hour != item.hour)) begin
                    st_out.last_checked_hour = item.hour;
                    if ((item.day >= FIRST_TURN_DAY) && ({2'd0, wanted} > st_in.turns_done)) begin
                        turn                     = 1'b1;
                        dir                      = st_in.next_turn_forward;
                        st_out.next_turn_forward = !st_in.next_turn_forward;
                        st_out.turns_done        = {2'd0, wanted};
                    end
                end
            end
            MODE_TICK: ;
            MODE_START: begin
                st_out.turns_done = '0;
            end
            default: ;
        endcase
    end

    assign result.heater_on      = st_out.heater;
    assign result.vent_on        = st_out.vent.running;
    assign result.fan_speed      = st_out.vent.fan_level;
    assign result.buzz           = buzz;
    assign result.turn_request   = turn;
    assign result.turn_direction = dir;

endmodule

`default_nettype wire

[hw/rtl/incubator_climate_controller.sv]
// ----------------------------------------------------------------------------
// incubator_climate_controller: heater, vent, humidity alarm and egg turning
// Top level: input register, event evaluation, state and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one event per transaction (sample, one-second tick or
//   start) with phase, temperature, humidity and clock time. Result channel
//   m_*: one result per event with heater, fan and pulse outputs.
//   Config channel cfg_*: write one threshold register by index; always
//   ready; write only while no event is in flight. Indexes past 7 are dropped.
//   Timing: the input register loads at the transaction edge; evaluation
//   then lands in the state and result registers, and the result is valid
//   once they load.
//   Throughput: one event per cycle while m_ready is high; evaluation is one
//   pass of compares and a counter increment between the two registers.
//   Stall: when m_ready is low the result is held, the input register keeps
//   one more event and s_ready drops once both are full.
//   Reset (aresetn low, synchronous): heater and fan off, counters and turn
//   count cleared, registers back to their defaults, both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module incubator_climate_controller
    import icc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_mode,
    input  wire logic [1:0]                 s_phase,
    input  wire logic signed [11:0]         s_temperature,
    input  wire logic [9:0]                 s_humidity,
    input  wire logic [4:0]                 s_day,
    input  wire logic [4:0]                 s_hour,
    input  wire logic [5:0]                 s_minute,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_heater_on,
    output logic                            m_vent_on,
    output logic [7:0]                      m_fan_speed,
    output logic                            m_buzz,
    output logic                            m_turn_request,
    output logic                            m_turn_direction
);

    cfg_t                   cfg;
    item_t                  item_reg;
    logic                   in_valid_reg;
    logic                   out_valid_reg;
    result_t                result_reg;
    result_t                result_next;
    ctl_state_t             st_reg;
    ctl_state_t             st_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg;
    logic [COUNT_WIDTH-1:0] elapsed_next;
    logic [COUNT_WIDTH-1:0] target_reg;
    logic [COUNT_WIDTH-1:0] target_next;
    logic                   advance;
    logic                   take_in;

    icc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // evaluate when the held event can move into a free result slot
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    icc_eval #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_eval (
        .item        (item_reg),
        .cfg         (cfg),
        .st_in       (st_reg),
        .elapsed_in  (elapsed_reg),
        .target_in   (target_reg),
        .st_out      (st_next),
        .elapsed_out (elapsed_next),
        .target_out  (target_next),
        .result      (result_next)
    );

    always_ff @(posedge aclk) begin
        if (take_in) begin
            item_reg.mode        <= mode_t'(s_mode);
            item_reg.phase       <= phase_t'(s_phase);
            item_reg.temperature <= s_temperature;
            item_reg.humidity    <= s_humidity;
            item_reg.day         <= s_day;
            item_reg.hour        <= s_hour;
            item_reg.minute      <= s_minute;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
            elapsed_reg   <= '0;
            target_reg    <= '0;
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
                elapsed_reg   <= elapsed_next;
                target_reg    <= target_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_heater_on      = result_reg.heater_on;
    assign m_vent_on        = result_reg.vent_on;
    assign m_fan_speed      = result_reg.fan_speed;
    assign m_buzz           = result_reg.buzz;
    assign m_turn_request   = result_reg.turn_request;
    assign m_turn_direction = result_reg.turn_direction;

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the incubator climate controller
// Drives sample, tick and start events through the valid/ready input channel,
// reprograms the thresholds between bursts, and checks every result against
// an event-level prediction of heater, vent, humidity alarm and egg turning.
// ----------------------------------------------------------------------------

import icc_pkg::*;

class incubator_tracker;

    // Counter ceiling of the instance, which runs at the default COUNT_WIDTH
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    cfg_t        regs;
    logic        heater;
    logic        force_vent;
    logic        vent_running;
    logic        next_fwd;
    logic [7:0]  fan_level;
    logic [7:0]  turns_done;
    logic [15:0] secs;
    logic [15:0] secs_target;
    logic [5:0]  last_buzz_minute;
    logic [4:0]  last_hour;
    result_t     due_outputs[$];
    int          errors;

    function new();
        regs.heat_on_below     = RST_HEAT_ON_BELOW;
        regs.heat_off_above    = RST_HEAT_OFF_ABOVE;
        regs.overheat_limit    = RST_OVERHEAT_LIMIT;
        regs.normal_hum_min    = RST_NORMAL_HUM_MIN;
        regs.normal_hum_max    = RST_NORMAL_HUM_MAX;
        regs.hatch_hum_min     = RST_HATCH_HUM_MIN;
        regs.hatch_hum_max     = RST_HATCH_HUM_MAX;
        regs.vent_rest_seconds = RST_VENT_REST;
        heater           = 1'b0;
        force_vent       = 1'b0;
        vent_running     = 1'b0;
        next_fwd         = 1'b0;
        fan_level        = FAN_OFF;
        turns_done       = '0;
        secs             = '0;
        secs_target      = '0;
        last_buzz_minute = '0;
        last_hour        = '0;
        errors           = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        case (idx)
            REG_HEAT_ON_BELOW:  regs.heat_on_below     = data[11:0];
            REG_HEAT_OFF_ABOVE: regs.heat_off_above    = data[11:0];
            REG_OVERHEAT_LIMIT: regs.overheat_limit    = data[11:0];
            REG_NORMAL_HUM_MIN: regs.normal_hum_min    = data[9:0];
            REG_NORMAL_HUM_MAX: regs.normal_hum_max    = data[9:0];
            REG_HATCH_HUM_MIN:  regs.hatch_hum_min     = data[9:0];
            REG_HATCH_HUM_MAX:  regs.hatch_hum_max     = data[9:0];
            REG_VENT_REST:      regs.vent_rest_seconds = data;
            default: ;
        endcase
    endfunction

    // One second of the vent cycle; does nothing while off or preheating
    function void vent_second(phase_t ph);
        if (ph == PHASE_OFF || ph == PHASE_PREHEAT) return;
        if (force_vent) secs_target = '0;
        if (secs != COUNT_MAX) secs++;
        if (secs < secs_target) return;
        secs = '0;
        if (!vent_running) begin
            vent_running = 1'b1;
            fan_level    = force_vent ? FAN_FAST : FAN_SLOW;
            force_vent   = 1'b0;
            secs_target  = 16'(VENT_RUN_SECONDS);
        end else begin
            vent_running = 1'b0;
            fan_level    = FAN_OFF;
            secs_target  = regs.vent_rest_seconds;
        end
    endfunction

    function void note_event(item_t ev);
        result_t            r;
        logic [9:0]         lo;
        logic [9:0]         hi;
        logic signed [11:0] t;
        int                 wanted;
        r = '0;
        t = ev.temperature;
        case (ev.mode)
            MODE_SAMPLE: begin
                lo = '0;
                hi = HUM_FULL;
                if (ev.phase != PHASE_OFF) begin
                    // overheat runs a vent step right away, ahead of the humidity check
                    if (t > $signed(regs.overheat_limit)) begin
                        force_vent = 1'b1;
                        vent_second(ev.phase);
                        heater = 1'b0;
                    end
                    if (t > $signed(regs.heat_off_above)) heater = 1'b0;
                    else if (t < $signed(regs.heat_on_below)) heater = 1'b1;
                end else begin
                    heater = 1'b0;
                end
                if (ev.phase == PHASE_NORMAL) begin
                    lo = regs.normal_hum_min;
                    hi = regs.normal_hum_max;
                end else if (ev.phase == PHASE_HATCH) begin
                    lo = regs.hatch_hum_min;
                    hi = regs.hatch_hum_max;
                end
                if (ev.humidity < lo || ev.humidity > hi) begin
                    if (last_buzz_minute != ev.minute) begin
                        last_buzz_minute = ev.minute;
                        r.buzz = 1'b1;
                    end
                    if (ev.humidity > hi) force_vent = 1'b1;
                end
                // record every new hour, even on early days with no turn due
                if (ev.phase == PHASE_NORMAL && last_hour != ev.hour) begin
                    last_hour = ev.hour;
                    if (ev.day >= FIRST_TURN_DAY) begin
                        wanted = int'(ev.day) * 2 - 1;
                        if (ev.hour < AFTERNOON_HOUR) wanted--;
                        if (wanted > int'(turns_done)) begin
                            r.turn_request   = 1'b1;
                            r.turn_direction = next_fwd;
                            next_fwd         = !next_fwd;
                            turns_done       = 8'(wanted);
                        end
                    end
                end
            end
            MODE_TICK:  vent_second(ev.phase);
            MODE_START: turns_done = '0;
            default: ;
        endcase
        r.heater_on = heater;
        r.vent_on   = vent_running;
        r.fan_speed = fan_level;
        due_outputs.push_back(r);
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_output(result_t got);
        result_t want;
        if (due_outputs.size() == 0) begin
            report("result transaction with no event outstanding");
            return;
        end
        want = due_outputs.pop_front();
        if (got.heater_on !== want.heater_on)
            report($sformatf("heater_on got %0d expected %0d", got.heater_on, want.heater_on));
        if (got.vent_on !== want.vent_on)
            report($sformatf("vent_on got %0d expected %0d", got.vent_on, want.vent_on));
        if (got.fan_speed !== want.fan_speed)
            report($sformatf("fan_speed got %0d expected %0d", got.fan_speed, want.fan_speed));
        if (got.buzz !== want.buzz)
            report($sformatf("buzz got %0d expected %0d", got.buzz, want.buzz));
        if (got.turn_request !== want.turn_request)
            report($sformatf("turn_request got %0d expected %0d",
                             got.turn_request, want.turn_request));
        if (got.turn_direction !== want.turn_direction)
            report($sformatf("turn_direction got %0d expected %0d",
                             got.turn_direction, want.turn_direction));
    endtask

endclass

module tb;

    localparam int MAX_GAP            = 17;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int RANDOM_PER_SETTING = 108;
    localparam int SETTING_COUNT      = 6;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_mode = '0;
    logic [1:0]                 s_phase = '0;
    logic signed [11:0]         s_temperature = '0;
    logic [9:0]                 s_humidity = '0;
    logic [4:0]                 s_day = '0;
    logic [4:0]                 s_hour = '0;
    logic [5:0]                 s_minute = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_heater_on;
    logic                       m_vent_on;
    logic [7:0]                 m_fan_speed;
    logic                       m_buzz;
    logic                       m_turn_request;
    logic                       m_turn_direction;

    incubator_tracker tracker = new();

    bit          steady = 1'b0;
    int unsigned cycle_count = 0;
    phase_t      sim_phase = PHASE_NORMAL;
    int          sim_day = 1;
    int          sim_hour = 0;
    int          sim_minute = 0;

    incubator_climate_controller uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_phase          (s_phase),
        .s_temperature    (s_temperature),
        .s_humidity       (s_humidity),
        .s_day            (s_day),
        .s_hour           (s_hour),
        .s_minute         (s_minute),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_heater_on      (m_heater_on),
        .m_vent_on        (m_vent_on),
        .m_fan_speed      (m_fan_speed),
        .m_buzz           (m_buzz),
        .m_turn_request   (m_turn_request),
        .m_turn_direction (m_turn_direction)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sample pre-edge values: what the block sees at this edge
    always @(posedge aclk) begin : monitor
        item_t   ev;
        result_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.heater_on      = m_heater_on;
                got.vent_on        = m_vent_on;
                got.fan_speed      = m_fan_speed;
                got.buzz           = m_buzz;
                got.turn_request   = m_turn_request;
                got.turn_direction = m_turn_direction;
                tracker.check_output(got);
            end
            if (s_valid && s_ready) begin
                ev.mode        = mode_t'(s_mode);
                ev.phase       = phase_t'(s_phase);
                ev.temperature = s_temperature;
                ev.humidity    = s_humidity;
                ev.day         = s_day;
                ev.hour        = s_hour;
                ev.minute      = s_minute;
                tracker.note_event(ev);
            end
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
        end
    end

    function int draw_gap();
        return steady ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Fill the bits above the register width with noise
    function logic [CFG_DATA_WIDTH-1:0] pad(int value, int width);
        logic [CFG_DATA_WIDTH-1:0] v;
        v = 16'($urandom);
        for (int b = 0; b < width; b++) v[b] = value[b];
        return v;
    endfunction

    function item_t next_random_item();
        item_t      ev;
        int         base;
        int         h;
        int         pick;
        logic [9:0] lo;
        logic [9:0] hi;
        if ($urandom_range(0, 99) < 15) begin
            ev.mode        = mode_t'($urandom_range(0, 3));
            ev.phase       = phase_t'($urandom_range(0, 3));
            ev.temperature = 12'($urandom);
            ev.humidity    = 10'($urandom);
            ev.day         = 5'($urandom);
            ev.hour        = 5'($urandom);
            ev.minute      = 6'($urandom);
            return ev;
        end
        // advance a plausible clock and hold the phase for long stretches
        if ($urandom_range(0, 99) < 4) sim_phase = phase_t'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 25) begin
            sim_hour += int'($urandom_range(1, 5));
            if (sim_hour > 23) begin
                sim_hour -= 24;
                sim_day = (sim_day == 31) ? 1 : sim_day + 1;
            end
        end
        if ($urandom_range(0, 99) < 40) sim_minute = (sim_minute + int'($urandom_range(1, 2))) % 60;
        pick = int'($urandom_range(0, 99));
        ev.mode = pick < 48 ? MODE_SAMPLE : pick < 94 ? MODE_TICK : pick < 98 ? MODE_START : MODE_NONE;
        ev.phase = sim_phase;
        case ($urandom_range(0, 3))
            0: base = int'($signed(tracker.regs.heat_on_below));
            1: base = int'($signed(tracker.regs.heat_off_above));
            2: base = int'($signed(tracker.regs.overheat_limit));
            default: base = int'($urandom_range(0, 2880)) - 880;
        endcase
        ev.temperature = 12'(base + int'($urandom_range(0, 32)) - 16);
        lo = '0;
        hi = HUM_FULL;
        if (sim_phase == PHASE_NORMAL) begin
            lo = tracker.regs.normal_hum_min;
            hi = tracker.regs.normal_hum_max;
        end else if (sim_phase == PHASE_HATCH) begin
            lo = tracker.regs.hatch_hum_min;
            hi = tracker.regs.hatch_hum_max;
        end
        h = ($urandom_range(0, 1) ? int'(lo) : int'(hi)) + int'($urandom_range(0, 40)) - 20;
        if ($urandom_range(0, 99) < 15) h = int'($urandom_range(0, 1023));
        if (h < 0) h = 0;
        if (h > 1023) h = 1023;
        ev.humidity = 10'(h);
        ev.day      = 5'(sim_day);
        ev.hour     = 5'(sim_hour);
        ev.minute   = 6'(sim_minute);
        return ev;
    endfunction

    // Hold valid and payload until the transaction is taken
    task send_item(item_t ev);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= ev.mode;
        s_phase       <= ev.phase;
        s_temperature <= ev.temperature;
        s_humidity    <= ev.humidity;
        s_day         <= ev.day;
        s_hour        <= ev.hour;
        s_minute      <= ev.minute;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task send_event(mode_t m, phase_t p, int t, int h, int d, int hr, int mi);
        item_t ev;
        ev.mode        = m;
        ev.phase       = p;
        ev.temperature = 12'(t);
        ev.humidity    = 10'(h);
        ev.day         = 5'(d);
        ev.hour        = 5'(hr);
        ev.minute      = 6'(mi);
        send_item(ev);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write
    task cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.due_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_setting(int kind);
        int on_t;
        int off_t;
        int over_t;
        int nmin;
        int nmax;
        int hmin;
        int hmax;
        int rest;
        case (kind)
            0: begin
                on_t = -880; off_t = -880; over_t = -880;
                nmin = 0; nmax = 0; hmin = 0; hmax = 0;
                rest = 1;
            end
            1: begin
                on_t = 2000; off_t = 2000; over_t = 2000;
                nmin = 1000; nmax = 1000; hmin = 1000; hmax = 1000;
                rest = 65535;
            end
            2: begin
                on_t = -2048; off_t = 2047; over_t = 2047;
                nmin = 0; nmax = 1023; hmin = 1023; hmax = 1023;
                rest = 0;
            end
            default: begin
                on_t   = int'($urandom_range(0, 2880)) - 880;
                off_t  = on_t + int'($urandom_range(0, 48));
                over_t = off_t + int'($urandom_range(0, 48));
                nmin   = int'($urandom_range(0, 900));
                nmax   = nmin + int'($urandom_range(0, 100));
                hmin   = int'($urandom_range(0, 900));
                hmax   = hmin + int'($urandom_range(0, 100));
                rest   = int'($urandom_range(0, 15));
            end
        endcase
        cfg_write(REG_HEAT_ON_BELOW, pad(on_t, 12));
        cfg_write(REG_HEAT_OFF_ABOVE, pad(off_t, 12));
        cfg_write(REG_OVERHEAT_LIMIT, pad(over_t, 12));
        cfg_write(REG_NORMAL_HUM_MIN, pad(nmin, 10));
        cfg_write(REG_NORMAL_HUM_MAX, pad(nmax, 10));
        cfg_write(REG_HATCH_HUM_MIN, pad(hmin, 10));
        cfg_write(REG_HATCH_HUM_MAX, pad(hmax, 10));
        cfg_write(REG_VENT_REST, pad(rest, 16));
        // an index past the register file must be dropped
        cfg_write(4'($urandom_range(8, 15)), 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin : result_sink
        int gap;
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        int waited;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // off phase forces the heater off; humidity past full scale alarms
        send_event(MODE_SAMPLE, PHASE_OFF, -2048, 1023, 1, 0, 1);
        send_event(MODE_SAMPLE, PHASE_PREHEAT, -880, 0, 1, 0, 1);
        send_event(MODE_TICK, PHASE_OFF, 0, 0, 1, 0, 1);
        send_event(MODE_TICK, PHASE_PREHEAT, 0, 0, 1, 0, 1);
        send_event(MODE_SAMPLE, PHASE_NORMAL, 2047, 500, 1, 0, 2);
        send_event(MODE_TICK, PHASE_NORMAL, 0, 0, 1, 0, 2);
        send_event(MODE_TICK, PHASE_NORMAL, 0, 0, 1, 0, 2);
        // early day: hour is recorded but no turn is due
        send_event(MODE_SAMPLE, PHASE_NORMAL, 600, 651, 2, 5, 2);
        send_event(MODE_SAMPLE, PHASE_NORMAL, 591, 449, 3, 12, 3);
        send_event(MODE_SAMPLE, PHASE_NORMAL, 617, 650, 3, 13, 3);
        send_event(MODE_SAMPLE, PHASE_NORMAL, 624, 450, 3, 13, 4);
        send_event(MODE_START, PHASE_NORMAL, 0, 0, 3, 13, 4);
        send_event(MODE_SAMPLE, PHASE_NORMAL, 625, 500, 31, 31, 63);
        send_event(MODE_NONE, PHASE_HATCH, 2000, 1000, 31, 23, 59);
        send_event(MODE_SAMPLE, PHASE_HATCH, 592, 749, 5, 1, 10);
        send_event(MODE_SAMPLE, PHASE_HATCH, 592, 901, 5, 1, 11);
        send_event(MODE_SAMPLE, PHASE_HATCH, 616, 750, 5, 1, 12);
        send_event(MODE_SAMPLE, PHASE_HATCH, 616, 900, 5, 1, 13);
        send_event(MODE_TICK, PHASE_HATCH, 0, 0, 5, 1, 13);
        send_event(MODE_TICK, PHASE_HATCH, 0, 0, 5, 1, 13);
        send_event(MODE_TICK, PHASE_HATCH, 0, 0, 5, 1, 13);
        send_event(MODE_SAMPLE, PHASE_NORMAL, 0, 1000, 0, 7, 0);
        send_event(MODE_SAMPLE, PHASE_OFF, 2047, 1001, 31, 31, 0);

        for (int kind = 0; kind < SETTING_COUNT; kind++) begin
            wait_idle();
            write_setting(kind);
            repeat (RANDOM_PER_SETTING) begin
                if ($urandom_range(0, 99) < 3) steady = !steady;
                send_item(next_random_item());
            end
        end

        // drain, bounded so a lost result shows up as a leftover
        s_valid <= 1'b0;
        waited = 0;
        @(posedge aclk);
        while (tracker.due_outputs.size() != 0 && waited < 4000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        if (tracker.due_outputs.size() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.due_outputs.size()));
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[incubator_climate_controller.f]
hw/rtl/icc_pkg.sv
hw/rtl/icc_cfg.sv
hw/rtl/icc_vent.sv
hw/rtl/icc_eval.sv
hw/rtl/incubator_climate_controller.sv
test/tb.sv
